// ===== rtl/weighted_moving_average_defines.svh =====
// Assertion macros for the RTL, included by weighted_moving_average.sv.
// With SYNTH defined the macros expand to nothing.
`ifndef WEIGHTED_MOVING_AVERAGE_DEFINES_SVH
`define WEIGHTED_MOVING_AVERAGE_DEFINES_SVH

`ifndef SYNTH

// Property that must hold at every clock edge outside reset.
`define WMA_ASSERT(lbl, ck, rn, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (prop)) else $error(msg);

// Condition in one cycle implies a consequence in the next cycle.
`define WMA_ASSERT_NEXT(lbl, ck, rn, cond, conseq, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (cond) |=> (conseq)) else $error(msg);

`else

`define WMA_ASSERT(lbl, ck, rn, prop, msg)
`define WMA_ASSERT_NEXT(lbl, ck, rn, cond, conseq, msg)

`endif

`endif

// ===== rtl/wma_pkg.sv =====
`timescale 1ns / 1ps

package wma_pkg;

  // Configuration port layout.
  localparam int CFG_IDX_BITS  = 1;
  localparam int CFG_DATA_BITS = 5;
  localparam int WL_BITS       = 5;

  localparam logic [CFG_IDX_BITS-1:0] CFG_ENABLE = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_WINDOW = 1'd1;

  localparam logic [WL_BITS-1:0] WINDOW_RESET = 5'd16;

  // Largest window the 5-bit window register can name.
  localparam int WINDOW_LIMIT = 31;

  // Width of n*(n+1) for the largest possible window.
  localparam int DEN_FULL_BITS = 10;

  // Sequencer states, one-hot.
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_PUT  = 4'b1000
  } state_t;

  // Commands from the sequencer to the accumulator.
  typedef struct packed {
    logic clear;
    logic start;
    logic full;
  } acc_cmd_t;

  // Divisor n*(n+1) of the weighted average for window length n.
  function automatic logic [DEN_FULL_BITS-1:0] window_den(input logic [WL_BITS-1:0] n);
    logic [DEN_FULL_BITS-1:0] nw;
    nw = DEN_FULL_BITS'(n);
    return DEN_FULL_BITS'(nw * (nw + DEN_FULL_BITS'(1)));
  endfunction

endpackage

// ===== rtl/wma_in_if.sv =====
`timescale 1ns / 1ps

// Input channel: one raw sample per item.
interface wma_in_if #(
  parameter int SAMPLE_BITS = 16
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

// ===== rtl/wma_out_if.sv =====
`timescale 1ns / 1ps

// Result channel: one weighted average per item.
interface wma_out_if #(
  parameter int SAMPLE_BITS = 16
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] average;

  modport source (output valid, output average, input ready);
  modport sink (input valid, input average, output ready);
endinterface

// ===== rtl/weighted_moving_average.sv =====
// Linearly weighted moving average of signed samples over the last N items,
// N taken from the window register (0 acts as 1, values above MAX_WINDOW or
// 31 saturate). The newest sample weighs N and the oldest 1; the result is
// 2*sum/(N*(N+1)) truncated toward zero, with that divisor also used while
// the window fills. An enabled item occupies the block through the
// shift-and-add weight multiply, one step per weight bit, then the
// restoring divider, one step per quotient bit, plus handover states. With
// enable low an item returns zero and leaves the window untouched. The
// result sits in an output register, so the next item is taken while it
// waits. Writing the window register empties the window; configure only
// while the block is idle.
`timescale 1ns / 1ps
`include "weighted_moving_average_defines.svh"

module weighted_moving_average #(
  parameter int MAX_WINDOW  = 16,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  wma_in_if.sink                               in_stream,
  wma_out_if.source                            out_stream,
  input  logic                                 cfg_we,
  input  logic [wma_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [wma_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

  localparam int WIN_MAX   = (MAX_WINDOW < wma_pkg::WINDOW_LIMIT) ?
                             MAX_WINDOW : wma_pkg::WINDOW_LIMIT;
  localparam int ADDR_BITS = $clog2(WIN_MAX);
  localparam int FILL_BITS = $clog2(WIN_MAX + 1);
  localparam int DEN_BITS  = $clog2(WIN_MAX * (WIN_MAX + 1) + 1);
  localparam int WT_BITS   = SAMPLE_BITS + $clog2(WIN_MAX * (WIN_MAX + 1));
  localparam int PT_BITS   = SAMPLE_BITS + $clog2(WIN_MAX + 1);

  wma_pkg::state_t                state_r, state_nxt;
  logic                           enable_r, enable_nxt;
  logic [wma_pkg::WL_BITS-1:0]    wl_r, wl_nxt;
  logic [FILL_BITS-1:0]           fill_r, fill_nxt;
  logic [ADDR_BITS-1:0]           head_r, head_nxt;
  logic                           zero_r, zero_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_BITS-1:0]  out_avg_r, out_avg_nxt;

  logic [wma_pkg::WL_BITS-1:0]    n_act;
  logic [DEN_BITS-1:0]            den;
  logic                           full;
  logic                           accept;
  logic                           out_free;
  logic [ADDR_BITS-1:0]           head_step;
  logic [ADDR_BITS-1:0]           store_addr;
  logic [wma_pkg::WL_BITS-1:0]    factor;
  logic                           store_we;
  logic [SAMPLE_BITS-1:0]         oldest;
  wma_pkg::acc_cmd_t              acc_cmd;
  logic                           acc_done;
  logic signed [WT_BITS-1:0]      weighted;
  logic                           div_start;
  logic                           div_done;
  logic signed [SAMPLE_BITS-1:0]  quotient;

  // Effective window length and the divisor that goes with it.
  always_comb begin
    if (wl_r == '0) begin
      n_act = wma_pkg::WL_BITS'(1);
    end else if (32'(wl_r) > WIN_MAX) begin
      n_act = wma_pkg::WL_BITS'(WIN_MAX);
    end else begin
      n_act = wl_r;
    end
    den = DEN_BITS'(wma_pkg::window_den(n_act));
  end

  // Ring addressing: while filling, write at the fill count; once full,
  // the oldest entry sits at head and is replaced by the new sample.
  assign full       = (32'(fill_r) == 32'(n_act));
  assign head_step  = (32'(head_r) + 32'd1 == 32'(n_act)) ? '0 : head_r + 1'b1;
  assign store_addr = full ? head_r : ADDR_BITS'(fill_r);
  assign factor     = full ? n_act : wma_pkg::WL_BITS'(fill_r) + wma_pkg::WL_BITS'(1);

  assign in_stream.ready = (state_r == wma_pkg::ST_IDLE);
  assign accept          = in_stream.valid && in_stream.ready;
  assign out_free        = !out_valid_r || out_stream.ready;

  // Sequencer, configuration writes and the output register.
  always_comb begin
    state_nxt     = state_r;
    enable_nxt    = enable_r;
    wl_nxt        = wl_r;
    fill_nxt      = fill_r;
    head_nxt      = head_r;
    zero_nxt      = zero_r;
    out_valid_nxt = out_valid_r;
    out_avg_nxt   = out_avg_r;
    acc_cmd       = '0;
    div_start     = 1'b0;
    store_we      = 1'b0;

    if (cfg_we) begin
      case (cfg_index)
        wma_pkg::CFG_ENABLE: begin
          enable_nxt = cfg_data[0];
        end
        wma_pkg::CFG_WINDOW: begin
          wl_nxt        = cfg_data;
          fill_nxt      = '0;
          head_nxt      = '0;
          acc_cmd.clear = 1'b1;
        end
        default: begin
        end
      endcase
    end

    if (out_valid_r && out_stream.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      wma_pkg::ST_IDLE: begin
        if (accept) begin
          if (enable_r) begin
            acc_cmd.start = 1'b1;
            acc_cmd.full  = full;
            store_we      = 1'b1;
            if (full) begin
              head_nxt = head_step;
            end else begin
              fill_nxt = fill_r + 1'b1;
            end
            zero_nxt  = 1'b0;
            state_nxt = wma_pkg::ST_MUL;
          end else begin
            zero_nxt  = 1'b1;
            state_nxt = wma_pkg::ST_PUT;
          end
        end
      end
      wma_pkg::ST_MUL: begin
        if (acc_done) begin
          div_start = 1'b1;
          state_nxt = wma_pkg::ST_DIV;
        end
      end
      wma_pkg::ST_DIV: begin
        if (div_done) begin
          state_nxt = wma_pkg::ST_PUT;
        end
      end
      wma_pkg::ST_PUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_avg_nxt   = zero_r ? '0 : quotient;
          state_nxt     = wma_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = wma_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= wma_pkg::ST_IDLE;
      enable_r    <= 1'b0;
      wl_r        <= wma_pkg::WINDOW_RESET;
      fill_r      <= '0;
      head_r      <= '0;
      zero_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      enable_r    <= enable_nxt;
      wl_r        <= wl_nxt;
      fill_r      <= fill_nxt;
      head_r      <= head_nxt;
      zero_r      <= zero_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_avg_r <= out_avg_nxt;
  end

  assign out_stream.valid   = out_valid_r;
  assign out_stream.average = out_avg_r;

  // Held samples; the oldest is read on the accepting cycle.
  wma_store #(
    .DEPTH     (WIN_MAX),
    .WIDTH     (SAMPLE_BITS),
    .ADDR_BITS (ADDR_BITS)
  ) u_store (
    .clk     (clk),
    .wr_en   (store_we),
    .wr_addr (store_addr),
    .wr_data (in_stream.sample),
    .rd_en   (accept),
    .rd_addr (head_r),
    .rd_data (oldest)
  );

  wma_acc #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .WT_BITS     (WT_BITS),
    .PT_BITS     (PT_BITS)
  ) u_acc (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (acc_cmd),
    .sample   (in_stream.sample),
    .factor   (factor),
    .oldest   (oldest),
    .done     (acc_done),
    .weighted (weighted)
  );

  wma_div #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .WT_BITS     (WT_BITS),
    .DEN_BITS    (DEN_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (weighted),
    .divisor  (den),
    .done     (div_done),
    .quotient (quotient)
  );

  // Checks on the window bookkeeping and the sequencer handover.
  `WMA_ASSERT(a_fill_in_window, clk, rst_n, 32'(fill_r) <= 32'(n_act), "fill count beyond window")
  `WMA_ASSERT(a_head_in_window, clk, rst_n, 32'(head_r) < 32'(n_act), "ring head beyond window")
  `WMA_ASSERT(a_acc_done_in_mul, clk, rst_n, acc_done |-> state_r == wma_pkg::ST_MUL, "stray multiply done")
  `WMA_ASSERT(a_div_done_in_div, clk, rst_n, div_done |-> state_r == wma_pkg::ST_DIV, "stray divide done")
  `WMA_ASSERT_NEXT(a_enabled_item_starts, clk, rst_n, accept && enable_r, state_r == wma_pkg::ST_MUL, "enabled item did not start")

endmodule

// ===== rtl/wma_store.sv =====
`timescale 1ns / 1ps

// Sample ring buffer: one write port and one registered read port.
module wma_store #(
  parameter int DEPTH     = 16,
  parameter int WIDTH     = 16,
  parameter int ADDR_BITS = 4
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [ADDR_BITS-1:0] wr_addr,
  input  logic [WIDTH-1:0]     wr_data,
  input  logic                 rd_en,
  input  logic [ADDR_BITS-1:0] rd_addr,
  output logic [WIDTH-1:0]     rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // A read and a write to the same entry return the old contents.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/wma_acc.sv =====
`timescale 1ns / 1ps

// Running totals of the window. The new sample is multiplied by its weight
// with a shift-and-add loop, one bit of the weight per cycle.
module wma_acc #(
  parameter int SAMPLE_BITS = 16,
  parameter int WT_BITS     = 26,
  parameter int PT_BITS     = 21
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  wma_pkg::acc_cmd_t                    cmd,
  input  logic signed [SAMPLE_BITS-1:0]        sample,
  input  logic [wma_pkg::WL_BITS-1:0]          factor,
  input  logic signed [SAMPLE_BITS-1:0]        oldest,
  output logic                                 done,
  output logic signed [WT_BITS-1:0]            weighted
);

  localparam int CNT_BITS = $clog2(wma_pkg::WL_BITS + 1);

  logic signed [WT_BITS-1:0]         wt_r, wt_nxt;
  logic signed [PT_BITS-1:0]         pt_r, pt_nxt;
  logic signed [WT_BITS-1:0]         acc_r, acc_nxt;
  logic signed [WT_BITS-1:0]         mcand_r, mcand_nxt;
  logic [wma_pkg::WL_BITS-1:0]       mplier_r, mplier_nxt;
  logic [CNT_BITS-1:0]               cnt_r, cnt_nxt;
  logic                              full_r, full_nxt;
  logic                              done_r, done_nxt;
  logic signed [PT_BITS-1:0]         old_term;
  logic signed [PT_BITS-1:0]         new_term;

  always_comb begin
    wt_nxt     = wt_r;
    pt_nxt     = pt_r;
    acc_nxt    = acc_r;
    mcand_nxt  = mcand_r;
    mplier_nxt = mplier_r;
    cnt_nxt    = cnt_r;
    full_nxt   = full_r;
    done_nxt   = 1'b0;
    // In the first step the multiplicand still holds the plain sample.
    new_term   = PT_BITS'(mcand_r);
    old_term   = full_r ? PT_BITS'(oldest) : '0;

    if (cmd.clear) begin
      wt_nxt  = '0;
      pt_nxt  = '0;
      cnt_nxt = '0;
    end else if (cmd.start) begin
      // A full window first loses one weight step on every held sample.
      acc_nxt    = cmd.full ? (wt_r - WT_BITS'(pt_r)) : wt_r;
      mcand_nxt  = WT_BITS'(sample);
      mplier_nxt = factor;
      full_nxt   = cmd.full;
      cnt_nxt    = CNT_BITS'(wma_pkg::WL_BITS);
    end else if (cnt_r != '0) begin
      if (mplier_r[0]) begin
        acc_nxt = acc_r + mcand_r;
      end
      mcand_nxt  = mcand_r <<< 1;
      mplier_nxt = mplier_r >> 1;
      cnt_nxt    = cnt_r - 1'b1;
      // The plain total takes the new sample and drops the oldest one.
      if (cnt_r == CNT_BITS'(wma_pkg::WL_BITS)) begin
        pt_nxt = pt_r - old_term + new_term;
      end
      if (cnt_r == CNT_BITS'(1)) begin
        wt_nxt   = acc_nxt;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wt_r   <= '0;
      pt_r   <= '0;
      cnt_r  <= '0;
      full_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      wt_r   <= wt_nxt;
      pt_r   <= pt_nxt;
      cnt_r  <= cnt_nxt;
      full_r <= full_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r    <= acc_nxt;
    mcand_r  <= mcand_nxt;
    mplier_r <= mplier_nxt;
  end

  assign done     = done_r;
  assign weighted = wt_r;

endmodule

// ===== rtl/wma_div.sv =====
`timescale 1ns / 1ps

// Restoring divider for 2*weighted / (n*(n+1)), one quotient bit per cycle.
// The quotient is truncated toward zero.
module wma_div #(
  parameter int SAMPLE_BITS = 16,
  parameter int WT_BITS     = 26,
  parameter int DEN_BITS    = 10
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic signed [WT_BITS-1:0]     dividend,
  input  logic [DEN_BITS-1:0]           divisor,
  output logic                          done,
  output logic signed [SAMPLE_BITS-1:0] quotient
);

  localparam int CNT_BITS = $clog2(SAMPLE_BITS + 1);

  logic [DEN_BITS-1:0]    rem_r, rem_nxt;
  logic [SAMPLE_BITS-1:0] quo_r, quo_nxt;
  logic [DEN_BITS-1:0]    den_r, den_nxt;
  logic                   neg_r, neg_nxt;
  logic [CNT_BITS-1:0]    cnt_r, cnt_nxt;
  logic                   done_r, done_nxt;
  logic [WT_BITS-1:0]     twice;
  logic [WT_BITS-1:0]     mag;
  logic [DEN_BITS:0]      trial;
  logic [DEN_BITS:0]      trial_diff;
  logic                   fits;

  always_comb begin
    twice      = {dividend[WT_BITS-2:0], 1'b0};
    mag        = dividend[WT_BITS-1] ? (~twice + 1'b1) : twice;
    trial      = {rem_r, quo_r[SAMPLE_BITS-1]};
    trial_diff = trial - {1'b0, den_r};
    fits       = (trial >= {1'b0, den_r});

    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    neg_nxt  = neg_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;

    if (start) begin
      // The quotient fits in SAMPLE_BITS, so the upper part is below the divisor.
      rem_nxt = DEN_BITS'(mag[WT_BITS-1:SAMPLE_BITS]);
      quo_nxt = mag[SAMPLE_BITS-1:0];
      den_nxt = divisor;
      neg_nxt = dividend[WT_BITS-1];
      cnt_nxt = CNT_BITS'(SAMPLE_BITS);
    end else if (cnt_r != '0) begin
      // Dividend bits leave the top of quo_r while quotient bits enter below.
      rem_nxt = fits ? trial_diff[DEN_BITS-1:0] : trial[DEN_BITS-1:0];
      quo_nxt = {quo_r[SAMPLE_BITS-2:0], fits};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_BITS'(1)) begin
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
    neg_r <= neg_nxt;
  end

  assign done     = done_r;
  assign quotient = neg_r ? (~quo_r + 1'b1) : quo_r;

endmodule
